// ===== hw/rtl/lsag_pkg.sv =====
// ---------------------------------------------------------------------------
// Light-sensor auto-gain package
// Shared range-state type, gain step codes and fixed threshold constants.
// ---------------------------------------------------------------------------
package lsag_pkg;

	// Width of each count field on the input stream.
	localparam int unsigned COUNT_FIELD_BITS = 16;

	// Gain step codes.
	localparam logic [1:0] GAIN_1X  = 2'd0;
	localparam logic [1:0] GAIN_4X  = 2'd1;
	localparam logic [1:0] GAIN_16X = 2'd2;
	localparam logic [1:0] GAIN_64X = 2'd3;

	// Full scale at 1x gain and 50 ms, and the 80 percent thresholds of the
	// full scale divided by 1, 4, 16, 64 and 128.
	localparam int unsigned STEP_UNIT  = 18;
	localparam int unsigned FULL_SCALE = STEP_UNIT * 1024;
	localparam int unsigned THR0 = (FULL_SCALE * 8) / 10;
	localparam int unsigned THR1 = ((FULL_SCALE / 4) * 8) / 10;
	localparam int unsigned THR2 = ((FULL_SCALE / 16) * 8) / 10;
	localparam int unsigned THR3 = ((FULL_SCALE / 64) * 8) / 10;
	localparam int unsigned THR4 = ((FULL_SCALE / 128) * 8) / 10;

	// Timing register values: 256 minus the step unit times the grade.
	localparam logic [7:0] TIMING_50MS  = 8'(256 - STEP_UNIT * 1);
	localparam logic [7:0] TIMING_100MS = 8'(256 - STEP_UNIT * 2);

	// Measuring range held between items.
	typedef struct packed {
		logic [1:0] gain;
		logic       reduce;
		logic       long_time;
	} lsag_range_t;

	// Outcome of one decision.
	typedef struct packed {
		lsag_range_t range;
		logic        changed;
	} lsag_decision_t;

endpackage

// ===== hw/rtl/lsag_decide.sv =====
// ---------------------------------------------------------------------------
// Light-sensor auto-gain range decision
// Combinational step of the range ladder for one measurement.
// ---------------------------------------------------------------------------
module lsag_decide #(
	parameter int unsigned CW = 16
) (
	input  logic [CW-1:0]          clear_count,
	input  logic [CW-1:0]          ir_count,
	input  lsag_pkg::lsag_range_t  cur,
	output lsag_pkg::lsag_decision_t result
);
	import lsag_pkg::*;

	function automatic logic both_below(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] t);
		both_below = (a < t) && (b < t);
	endfunction

	function automatic logic either_above(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] t);
		either_above = (a > t) || (b > t);
	endfunction

	logic [31:0] c0, r0;
	logic [31:0] c2, r2, c4, r4, c6, r6, c7, r7;
	logic [31:0] c_scaled, r_scaled;
	lsag_range_t nxt;

	assign c0 = 32'(clear_count);
	assign r0 = 32'(ir_count);
	assign c2 = c0 >> 2;
	assign r2 = r0 >> 2;
	assign c4 = c0 >> 4;
	assign r4 = r0 >> 4;
	assign c6 = c0 >> 6;
	assign r6 = r0 >> 6;
	assign c7 = c0 >> 7;
	assign r7 = r0 >> 7;
	// Counts times 1.5 for the reduce-factor release test.
	assign c_scaled = c0 + (c0 >> 1);
	assign r_scaled = r0 + (r0 >> 1);

	always_comb begin
		nxt = cur;
		if (cur.long_time) begin
			if (either_above(c7, r7, THR4)) begin
				nxt.long_time = 1'b0;
			end
		end else if (cur.reduce) begin
			if (both_below(c_scaled, r_scaled, THR0)) begin
				nxt.reduce = 1'b0;
			end
		end else begin
			unique case (cur.gain)
				GAIN_1X: begin
					if (both_below(c0, r0, THR1)) begin
						nxt.gain = GAIN_4X;
					end else if (either_above(c0, r0, THR0)) begin
						nxt.reduce = 1'b1;
					end
				end
				GAIN_4X: begin
					if (both_below(c2, r2, THR2)) begin
						nxt.gain = GAIN_16X;
					end else if (either_above(c2, r2, THR1)) begin
						nxt.gain = GAIN_1X;
					end
				end
				GAIN_16X: begin
					if (both_below(c4, r4, THR3)) begin
						nxt.gain = GAIN_64X;
					end else if (either_above(c4, r4, THR2)) begin
						nxt.gain = GAIN_4X;
					end
				end
				default: begin
					if (both_below(c6, r6, THR4)) begin
						nxt.long_time = 1'b1;
					end else if (either_above(c6, r6, THR3)) begin
						nxt.gain = GAIN_16X;
					end
				end
			endcase
		end
	end

	assign result.range   = nxt;
	// A change of the reduce flag alone does not count as a range change.
	assign result.changed = (nxt.gain != cur.gain) || (nxt.long_time != cur.long_time);

endmodule

// ===== hw/rtl/light_sensor_auto_gain_unit.sv =====
// ---------------------------------------------------------------------------
// Light-sensor auto-gain unit
// Steps the gain and integration range of a color sensor per measurement.
// ---------------------------------------------------------------------------
// Each input item is one measurement (clear and IR counts); each produces
// exactly one result item carrying the new gain step, the reduce flag, the
// integration flag, the matching timing register value and a changed flag.
// An item passes an input register and a result register, so its result is
// offered on the output once it has moved into the result register, and one item
// is taken every cycle as long as results are drained. The range state
// advances at the edge where an item moves from the input register into the
// result register, so the next item always sees the range left by the one
// before it. When the result register is full and not taken, the input
// register holds and the input side stalls once that register is also full.
module light_sensor_auto_gain_unit #(
	// Counts are masked to this many low bits before use (8 to 24), capped at 16.
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_axis_tdata, from bit 0: clear_count[15:0], ir_count[15:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// m_axis_tdata, from bit 0: gain_step[1:0], reduce_active, long_integration,
	// timing_register[7:0], range_changed, three zero pad bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata
);
	import lsag_pkg::*;

	// Effective count width: the field width caps the mask.
	localparam int unsigned CW =
		(COUNT_BITS < COUNT_FIELD_BITS) ? COUNT_BITS : COUNT_FIELD_BITS;

	logic              valid_s1;
	logic [CW-1:0]     clear_s1;
	logic [CW-1:0]     ir_s1;
	logic              valid_s2;
	lsag_decision_t    result_s2;
	lsag_range_t       range_q;
	lsag_decision_t    decision;
	logic              advance_s1;
	logic              accept_in;

	// The result register can take a new item when empty or being drained.
	assign advance_s1    = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	lsag_decide #(
		.CW(CW)
	) u_decide (
		.clear_count (clear_s1),
		.ir_count    (ir_s1),
		.cur         (range_q),
		.result      (decision)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			range_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					range_q <= decision.range;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			clear_s1 <= s_axis_tdata[CW-1:0];
			ir_s1    <= s_axis_tdata[COUNT_FIELD_BITS +: CW];
		end
		if (advance_s1 && valid_s1) begin
			result_s2 <= decision;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		3'b000,
		result_s2.changed,
		result_s2.range.long_time ? TIMING_100MS : TIMING_50MS,
		result_s2.range.long_time,
		result_s2.range.reduce,
		result_s2.range.gain
	};

endmodule

// ===== tb/sv/light_sensor_auto_gain_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Light-sensor auto-gain unit testbench
// Streams clear and IR measurements into the unit, predicts the next range
// for every accepted item and compares each result item field by field.
// ---------------------------------------------------------------------------
// The run starts with a directed walk along the whole gain ladder, through
// the reduce factor and in and out of long integration, hitting thresholds
// at their edges. Random scenes, each of one brightness range, follow,
// mixed with counts close to the scaled thresholds and with fully random
// counts. Both stream sides idle at random, and once the result side holds
// off long enough for the unit to fill up and stall its input.
module light_sensor_auto_gain_unit_tb;
	import lsag_pkg::*;

	localparam int unsigned COUNT_BITS   = 16;
	localparam int unsigned COUNT_MASK   = (1 << COUNT_BITS) - 1;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned DRAIN_CYCLES = 8;
	// Time limit, far above the slowest correct run.
	localparam int unsigned RUN_LIMIT    = 3_000_000;

	// One result item as it leaves the unit, lowest field last.
	typedef struct packed {
		logic       range_changed;
		logic [7:0] timing_register;
		logic       long_integration;
		logic       reduce_active;
		logic [1:0] gain_step;
	} range_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// clear_count[15:0], ir_count[15:0]
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// gain_step[1:0], reduce_active, long_integration, timing_register[7:0],
	// range_changed, three zero pad bits
	logic [15:0] m_axis_tdata;

	// Range the predictor believes the unit holds.
	logic [1:0] sensor_gain;
	logic       sensor_reduce;
	logic       sensor_long;

	range_result_t pending_ranges[$];
	int unsigned   mismatch_count;

	// Idle control for the two stream sides.
	bit          input_idle_on;
	bit          result_stall_on;
	int unsigned result_hold_request;

	light_sensor_auto_gain_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Works out the range after one measurement and advances the predicted
	// state. The mode order matters: long integration only watches for bright
	// light, an active reduce factor only watches for the light to drop, and
	// only then does the gain ladder move.
	function automatic range_result_t predict_range_step(input logic [15:0] clear_meas,
			input logic [15:0] ir_meas);
		int unsigned   c;
		int unsigned   r;
		logic [1:0]    gain_before;
		logic          long_before;
		range_result_t res;
		c = clear_meas & COUNT_MASK;
		r = ir_meas & COUNT_MASK;
		gain_before = sensor_gain;
		long_before = sensor_long;
		if (sensor_long) begin
			if ((c >> 7) > THR4 || (r >> 7) > THR4)
				sensor_long = 1'b0;
		end else if (sensor_reduce) begin
			// The reduce factor scales the counts by one and a half.
			if ((c + (c >> 1)) < THR0 && (r + (r >> 1)) < THR0)
				sensor_reduce = 1'b0;
		end else begin
			case (sensor_gain)
				GAIN_1X: begin
					if (c < THR1 && r < THR1)
						sensor_gain = GAIN_4X;
					else if (c > THR0 || r > THR0)
						sensor_reduce = 1'b1;
				end
				GAIN_4X: begin
					if ((c >> 2) < THR2 && (r >> 2) < THR2)
						sensor_gain = GAIN_16X;
					else if ((c >> 2) > THR1 || (r >> 2) > THR1)
						sensor_gain = GAIN_1X;
				end
				GAIN_16X: begin
					if ((c >> 4) < THR3 && (r >> 4) < THR3)
						sensor_gain = GAIN_64X;
					else if ((c >> 4) > THR2 || (r >> 4) > THR2)
						sensor_gain = GAIN_4X;
				end
				default: begin
					// At the top of the ladder a dark scene doubles the
					// integration time instead.
					if ((c >> 6) < THR4 && (r >> 6) < THR4)
						sensor_long = 1'b1;
					else if ((c >> 6) > THR3 || (r >> 6) > THR3)
						sensor_gain = GAIN_16X;
				end
			endcase
		end
		res.gain_step        = sensor_gain;
		res.reduce_active    = sensor_reduce;
		res.long_integration = sensor_long;
		res.timing_register  = sensor_long ? TIMING_100MS : TIMING_50MS;
		// A change of the reduce factor alone does not count as a change.
		res.range_changed    = (sensor_gain != gain_before) || (sensor_long != long_before);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		else if (sel < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	// A count a few steps around one of the thresholds, scaled by one of the
	// gain or integration divisors, so that the compares are hit at their
	// edges.
	function automatic logic [15:0] pick_threshold_count();
		int unsigned thr;
		int unsigned scale;
		int          v;
		case ($urandom_range(0, 4))
			0: thr = THR0;
			1: thr = THR1;
			2: thr = THR2;
			3: thr = THR3;
			default: thr = THR4;
		endcase
		case ($urandom_range(0, 5))
			0: scale = 0;
			1: scale = 2;
			2: scale = 4;
			3: scale = 6;
			4: scale = 7;
			default: scale = 1;
		endcase
		v = int'(thr << scale) + int'($urandom_range(0, 2 << scale)) - int'(1 << scale);
		// The reduce compare uses one and a half times the count.
		if (scale == 1)
			v = (int'(thr) * 2) / 3 + int'($urandom_range(0, 4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// Sends one measurement, waiting out a random gap first when idling is
	// on, and records the predicted range once the item is accepted.
	task automatic send_measurement(input logic [15:0] clear_cnt, input logic [15:0] ir_cnt);
		int unsigned gap;
		gap = input_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ir_cnt, clear_cnt};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_ranges.push_back(predict_range_step(clear_cnt, ir_cnt));
	endtask

	// Walks up the whole ladder and back, touching thresholds at their edges, some
	// from both sides, including the reduce factor and long integration.
	task automatic test_ladder_walk();
		input_idle_on   = 1'b1;
		result_stall_on = 1'b1;
		// Bright clear at 1x sets the reduce factor, gain stays.
		send_measurement(16'hFFFF, 16'h0000);
		// Still too bright with the factor applied.
		send_measurement(16'hFFFF, 16'hFFFF);
		// Just below the reduced threshold clears the factor.
		send_measurement(16'd9829, 16'd0);
		// Bright IR alone sets the factor again, just one above threshold.
		send_measurement(16'd0, 16'(THR0 + 1));
		// One count too many keeps the factor.
		send_measurement(16'd0, 16'd9830);
		send_measurement(16'd0, 16'd0);
		// Dark at 1x steps to 4x.
		send_measurement(16'(THR1 - 1), 16'(THR1 - 1));
		// Exactly on the 4x bright threshold: no change.
		send_measurement(16'(THR1 * 4 + 3), 16'd0);
		// One above on IR steps back to 1x.
		send_measurement(16'd0, 16'((THR1 + 1) * 4));
		send_measurement(16'd0, 16'd0);
		send_measurement(16'(THR2 * 4 - 1), 16'(THR2 * 4 - 1));
		// Bright at 16x steps down, then dark steps up again.
		send_measurement(16'd0, 16'((THR2 + 1) * 16));
		send_measurement(16'd0, 16'd0);
		send_measurement(16'd0, 16'd0);
		// Bright at 64x steps down, then back up.
		send_measurement(16'd0, 16'hFFFF);
		send_measurement(16'd0, 16'd0);
		// Just dark enough at 64x selects 100 ms.
		send_measurement(16'(THR4 * 64 - 1), 16'(THR4 * 64 - 1));
		// Exactly on the long-integration bright threshold: stays.
		send_measurement(16'(THR4 * 128 + 127), 16'(THR4 * 128 + 127));
		// One above on IR returns to 50 ms.
		send_measurement(16'd0, 16'((THR4 + 1) * 128));
		send_measurement(16'd0, 16'd0);
		send_measurement(16'hFFFF, 16'd0);
		send_measurement(16'hFFFF, 16'hFFFF);
	endtask

	// Scenes of a random brightness that hold for a few measurements, so the
	// ladder climbs and falls through all of its states, mixed with edge
	// counts and fully random counts.
	task automatic test_random_scenes(input int unsigned item_total);
		int unsigned sent;
		int unsigned scene_len;
		int unsigned bright_bits;
		int unsigned kind;
		logic [15:0] clear_cnt;
		logic [15:0] ir_cnt;
		sent = 0;
		while (sent < item_total) begin
			// Switch idling patterns now and then, leaving stretches without
			// any gaps on either side.
			if ($urandom_range(0, 5) == 0) begin
				input_idle_on   = $urandom_range(0, 2) != 0;
				result_stall_on = $urandom_range(0, 2) != 0;
			end
			scene_len   = $urandom_range(2, 8);
			bright_bits = $urandom_range(0, 16);
			repeat (scene_len) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					clear_cnt = 16'(($urandom & ((1 << bright_bits) - 1)) | (1 << bright_bits >> 1));
					ir_cnt    = clear_cnt >> $urandom_range(0, 4);
				end else if (kind < 9) begin
					clear_cnt = pick_threshold_count();
					ir_cnt    = $urandom_range(0, 1) ? pick_threshold_count() : 16'd0;
					if ($urandom_range(0, 1))
						{clear_cnt, ir_cnt} = {ir_cnt, clear_cnt};
				end else begin
					clear_cnt = 16'($urandom);
					ir_cnt    = 16'($urandom);
				end
				send_measurement(clear_cnt, ir_cnt);
				sent++;
			end
		end
	endtask

	// The result side holds off for a long stretch while items keep coming
	// back to back, so the unit fills both registers and stalls its input.
	task automatic test_result_backpressure();
		input_idle_on       = 1'b0;
		result_hold_request = 80;
		repeat (24)
			send_measurement(16'($urandom), $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
		input_idle_on   = 1'b1;
		result_stall_on = 1'b1;
	endtask

	// Lets every expected result arrive, drains the pipeline and reports the outcome.
	task automatic finish_run();
		s_axis_tvalid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	// Result side: ready is driven at each edge, with random stalls and a
	// long hold-off when one is requested.
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left     = 0;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_hold_request > 0) begin
				hold_left           = result_hold_request;
				result_hold_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = result_stall_on ? pick_gap() : 0;
			end
		end
	end

	// Every accepted result item is compared with the oldest prediction.
	always @(posedge clk) begin
		range_result_t want;
		range_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[12:0];
			if (pending_ranges.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result item with nothing predicted: tdata=%h", m_axis_tdata);
			end else begin
				want = pending_ranges.pop_front();
				if (got.gain_step != want.gain_step
						|| got.reduce_active != want.reduce_active
						|| got.long_integration != want.long_integration
						|| got.timing_register != want.timing_register
						|| got.range_changed != want.range_changed
						|| m_axis_tdata[15:13] != 3'b000) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"range mismatch: gain %0d/%0d reduce %0d/%0d long %0d/%0d ",
							"timing %0d/%0d changed %0d/%0d pad %0d (expected/actual)"},
							want.gain_step, got.gain_step,
							want.reduce_active, got.reduce_active,
							want.long_integration, got.long_integration,
							want.timing_register, got.timing_register,
							want.range_changed, got.range_changed,
							m_axis_tdata[15:13]);
				end
			end
		end
	end

	// Stops a hung run.
	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		s_axis_tvalid       = 1'b0;
		s_axis_tdata        = '0;
		sensor_gain         = GAIN_1X;
		sensor_reduce       = 1'b0;
		sensor_long         = 1'b0;
		mismatch_count      = 0;
		input_idle_on       = 1'b1;
		result_stall_on     = 1'b1;
		result_hold_request = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ladder_walk();
		test_random_scenes(180);
		test_result_backpressure();
		test_random_scenes(180);
		finish_run();
	end

endmodule
